// ===== hw/rtl/ata_pkg.sv =====
// ----------------------------------------------------------------------------
// ata_pkg
// Shared widths, constants and register indexes of the averaged temperature
// alarm.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int CPV_W  = 16;
  localparam int TEMP_W = 16;
  localparam int CFG_W  = 16;
  localparam int SCNT_W = 9;

  localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

  typedef enum logic [1:0] {
    CFG_COUNTS_PER_VOLT,
    CFG_SAMPLE_COUNT,
    CFG_CRITICAL_LEVEL,
    CFG_HYSTERESIS
  } cfg_idx_t;

endpackage

// ===== hw/rtl/averaged_temperature_alarm.sv =====
// A block's result goes through the queue, pop, multiply, range check, 16 divide steps
// and handoff, in that order; a saturated block skips the divide. Throughput: one sample
// word per cycle while the queue has room; the divider pops a block only when idle.
// A two-entry queue lets sampling continue while a division runs.
// Reset (synchronous, rst_n low): sum and count cleared, flag set to critical,
// registers to 2275, 16, 1120 and 80.
// ----------------------------------------------------------------------------
// averaged_temperature_alarm
// Block averaging of ADC samples into 1/16 degree temperature with a
// hysteresis alarm flag.
// ----------------------------------------------------------------------------
module averaged_temperature_alarm
  import ata_pkg::*;
#(
  parameter int ADC_BITS    = 12,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] in_raw_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TEMP_W-1:0]   out_temperature,
  output logic                out_critical,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int SUM_W = $clog2((2 ** ADC_BITS - 1) * MAX_SAMPLES + 1);
  localparam int N_W   = $clog2(MAX_SAMPLES + 1);
  localparam int Q_W   = SUM_W + N_W + CPV_W;

  localparam logic [CPV_W-1:0]  CPV_RESET   = 16'd2275;
  localparam logic [SCNT_W-1:0] SCNT_RESET  = 9'd16;
  localparam logic [TEMP_W-1:0] LEVEL_RESET = 16'd1120;
  localparam logic [TEMP_W-1:0] HYST_RESET  = 16'd80;

  logic [CPV_W-1:0]  counts_per_volt_r;
  logic [SCNT_W-1:0] sample_count_r;
  logic [TEMP_W-1:0] critical_level_r;
  logic [TEMP_W-1:0] hysteresis_r;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [SUM_W-1:0] push_sum;
  logic [N_W-1:0]   push_n;
  logic [CPV_W-1:0] push_cpv;
  logic [Q_W-1:0]   pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_per_volt_r <= CPV_RESET;
      sample_count_r    <= SCNT_RESET;
      critical_level_r  <= LEVEL_RESET;
      hysteresis_r      <= HYST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COUNTS_PER_VOLT: counts_per_volt_r <= cfg_data;
        CFG_SAMPLE_COUNT:    sample_count_r    <= cfg_data[SCNT_W-1:0];
        CFG_CRITICAL_LEVEL:  critical_level_r  <= cfg_data;
        CFG_HYSTERESIS:      hysteresis_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  ata_front #(
    .ADC_BITS    (ADC_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .SUM_W       (SUM_W),
    .N_W         (N_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_raw_sample   (in_raw_sample),
    .counts_per_volt (counts_per_volt_r),
    .sample_count    (sample_count_r),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_sum        (push_sum),
    .push_n          (push_n),
    .push_cpv        (push_cpv)
  );

  ata_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_sum, push_n, push_cpv}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ata_back #(
    .SUM_W (SUM_W),
    .N_W   (N_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_sum         (pop_data[Q_W-1 -: SUM_W]),
    .pop_n           (pop_data[CPV_W +: N_W]),
    .pop_cpv         (pop_data[CPV_W-1:0]),
    .critical_level  (critical_level_r),
    .hysteresis      (hysteresis_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temperature (out_temperature),
    .out_critical    (out_critical)
  );

endmodule

// ===== hw/rtl/ata_front.sv =====
// ----------------------------------------------------------------------------
// ata_front
// Accepts raw sample words, accumulates a block and hands each completed
// block, with the divisor terms in force at its last sample, to the queue.
// ----------------------------------------------------------------------------
module ata_front
  import ata_pkg::*;
#(
  parameter int ADC_BITS    = 12,
  parameter int MAX_SAMPLES = 256,
  parameter int SUM_W       = 20,
  parameter int N_W         = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] in_raw_sample,
  input  logic [CPV_W-1:0]    counts_per_volt,
  input  logic [SCNT_W-1:0]   sample_count,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [SUM_W-1:0]    push_sum,
  output logic [N_W-1:0]      push_n,
  output logic [CPV_W-1:0]    push_cpv
);

  logic [SUM_W-1:0] sum_r, sum_nxt, sum_acc;
  logic [N_W-1:0]   taken_r, taken_nxt, taken_inc;
  logic [N_W-1:0]   n_eff;
  logic             accept, block_done;

  always_comb begin
    if (sample_count == '0) begin
      n_eff = N_W'(1);
    end else if (32'(sample_count) > MAX_SAMPLES) begin
      n_eff = N_W'(MAX_SAMPLES);
    end else begin
      n_eff = N_W'(sample_count);
    end
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign sum_acc    = sum_r + SUM_W'(in_raw_sample);
  assign taken_inc  = taken_r + N_W'(1);
  assign block_done = (taken_inc >= n_eff);

  assign push_valid = accept && block_done;
  assign push_sum   = sum_acc;
  assign push_n     = n_eff;
  assign push_cpv   = counts_per_volt;

  always_comb begin
    sum_nxt   = sum_r;
    taken_nxt = taken_r;
    if (accept) begin
      if (block_done) begin
        sum_nxt   = '0;
        taken_nxt = '0;
      end else begin
        sum_nxt   = sum_acc;
        taken_nxt = taken_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      taken_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

// ===== hw/rtl/ata_queue.sv =====
// ----------------------------------------------------------------------------
// ata_queue
// Two-entry queue of completed blocks between the accumulator and the
// divider.
// ----------------------------------------------------------------------------
module ata_queue #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] data_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = data_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ata_back.sv =====
// ----------------------------------------------------------------------------
// ata_back
// Converts one block sum to temperature with a bit-serial divider, updates
// the hysteresis flag and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module ata_back
  import ata_pkg::*;
#(
  parameter int SUM_W = 20,
  parameter int N_W   = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  logic [SUM_W-1:0]  pop_sum,
  input  logic [N_W-1:0]    pop_n,
  input  logic [CPV_W-1:0]  pop_cpv,
  input  logic [TEMP_W-1:0] critical_level,
  input  logic [TEMP_W-1:0] hysteresis,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TEMP_W-1:0] out_temperature,
  output logic              out_critical
);

  localparam int NUM_W = SUM_W + 11;
  localparam int DIV_W = CPV_W + N_W;
  localparam int DEN_W = DIV_W + TEMP_W;
  localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int STEP_W = $clog2(TEMP_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [SUM_W-1:0]  sum_r;
  logic [N_W-1:0]    n_r;
  logic [CPV_W-1:0]  cpv_r;
  logic [CMP_W-1:0]  rem_r, den_r;
  logic [TEMP_W-1:0] q_r;
  logic [STEP_W-1:0] step_r;
  logic              flag_r;
  logic              out_valid_r;
  logic [TEMP_W-1:0] out_temperature_r;
  logic [NUM_W-1:0]  sum_ext;
  logic [DIV_W-1:0]  div_prod;
  logic              rem_ge;
  logic              flag_nxt;
  logic              out_free;

  assign pop_ready       = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_temperature = out_temperature_r;
  assign out_critical    = flag_r;
  assign out_free        = !out_valid_r || out_ready;

  // The factor 1600 is 1024 + 512 + 64.
  assign sum_ext  = NUM_W'(sum_r);
  assign div_prod = DIV_W'(cpv_r) * DIV_W'(n_r);
  assign rem_ge   = (rem_r >= den_r);

  always_comb begin
    flag_nxt = flag_r;
    if (q_r > critical_level) begin
      flag_nxt = 1'b1;
    end else if (({1'b0, q_r} + {1'b0, hysteresis}) < {1'b0, critical_level}) begin
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flag_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            sum_r   <= pop_sum;
            n_r     <= pop_n;
            cpv_r   <= pop_cpv;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          rem_r   <= CMP_W'((sum_ext << 10) + (sum_ext << 9) + (sum_ext << 6));
          den_r   <= CMP_W'({div_prod, {TEMP_W{1'b0}}});
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          step_r <= '0;
          den_r  <= den_r >> 1;
          if (rem_ge) begin
            q_r     <= TEMP_MAX;
            state_r <= S_DONE;
          end else begin
            q_r     <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_ge) begin
            rem_r <= rem_r - den_r;
          end
          q_r    <= {q_r[TEMP_W-2:0], rem_ge};
          den_r  <= den_r >> 1;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(TEMP_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_temperature_r <= q_r;
            flag_r            <= flag_nxt;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end else begin
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
